/* design/dtqp_pkg.sv */
// ----------------------------------------------------------------------------
// dtqp_pkg
// Shared types and constants of the dpcm table quantizer and packer.
// ----------------------------------------------------------------------------
package dtqp_pkg;

	// parameter defaults
	localparam int MAX_CHANNELS_DEF = 4;
	localparam int TABLE_DEPTH_DEF  = 32;
	localparam int WORD_BITS_DEF    = 16;

	// field and datapath widths
	localparam int VALUE_W       = 16;
	localparam int PRED_W        = 18;
	localparam int DELTA_W       = 20;
	localparam int CODE_BITS_MAX = 5;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 6;

	// predictor saturation limits
	localparam logic signed [PRED_W:0] PRED_MAX = (PRED_W+1)'(131071);
	localparam logic signed [PRED_W:0] PRED_MIN = -(PRED_W+1)'(131072);

	// register reset values
	localparam logic [2:0] CODE_BITS_RST     = 3'd4;
	localparam logic [5:0] TABLE_ENTRIES_RST = 6'd16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CODE_BITS     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TABLE_ENTRIES = 2'd1;

	// item operations
	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_START  = 2'd1,
		OP_ENCODE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

endpackage

/* design/dtqp_ram.sv */
// ----------------------------------------------------------------------------
// dtqp_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module dtqp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* design/dpcm_table_quantizer_packer.sv */
// ----------------------------------------------------------------------------
// dpcm_table_quantizer_packer
// DPCM encoder: nearest-entry search over a loaded quantizer table, per-channel
// saturating predictor, LSB-first packing of indices into output words.
// ----------------------------------------------------------------------------
//
//  channel | signals                                          | handshake
//  --------+--------------------------------------------------+-----------------
//  in      | op, channel, entry_index, value, frame_end       | in_valid/in_ready
//  out     | packed_word, last_word                           | out_valid/out_ready
//  cfg     | cfg_index, cfg_data                              | cfg_valid/cfg_ready
//
//  table writes, start items and dropped items leave the block idle.
//  an encode item scans n entries (n = entries searched, up to TABLE_DEPTH):
//  one table RAM read port feeds one abs-difference compare unit per cycle.
//  a word still waiting on the output stalls the update cycle of the next
//  encode that emits; reset clears predictors and packer and resets registers at once.
//  the table itself has no reset and must be written before it is searched.
//
module dpcm_table_quantizer_packer #(
	parameter int MAX_CHANNELS = dtqp_pkg::MAX_CHANNELS_DEF,
	parameter int TABLE_DEPTH  = dtqp_pkg::TABLE_DEPTH_DEF,
	parameter int WORD_BITS    = dtqp_pkg::WORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input items
	input  logic                                in_valid,
	output logic                                in_ready,
	input  dtqp_pkg::op_t                       op,
	input  logic [1:0]                          channel,
	input  logic [4:0]                          entry_index,
	input  logic signed [dtqp_pkg::VALUE_W-1:0] value,
	input  logic                                frame_end,
	// result items
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [WORD_BITS-1:0]                packed_word,
	output logic                                last_word,
	// configuration writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dtqp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dtqp_pkg::CFG_DATA_W-1:0]     cfg_data
);

	import dtqp_pkg::*;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int POS_W = $clog2(WORD_BITS + CODE_BITS_MAX + 1);

	state_t state_q, state_d;

	// configuration registers
	logic [2:0] code_bits_q;
	logic [5:0] table_entries_q;

	// predictors and packer
	logic signed [PRED_W-1:0] pred_q [MAX_CHANNELS];
	logic [WORD_BITS-1:0]     acc_q;
	logic [POS_W-1:0]         pos_q;

	// per-item working registers
	logic [CH_W-1:0]           ch_q;
	logic signed [DELTA_W-1:0] delta_q;
	logic                      fend_q;
	logic [CNT_W-1:0]          n_q;
	logic [CNT_W-1:0]          addr_q;
	logic                      cmp_v_s1;
	logic [CNT_W-1:0]          cmp_idx_s1;
	logic [IDX_W-1:0]          best_q;
	logic [DELTA_W-1:0]        bestd_q;
	logic signed [VALUE_W-1:0] bestv_q;

	// output register
	logic                 out_valid_q;
	logic [WORD_BITS-1:0] word_q;
	logic                 last_q;

	// combinational signals
	logic                      in_fire, ch_ok, ent_ok;
	logic [CNT_W-1:0]          n_d;
	logic [2:0]                bits;
	logic [CODE_BITS_MAX-1:0]  code;
	logic [POS_W-1:0]          new_pos;
	logic [WORD_BITS-1:0]      new_acc;
	logic                      emit, out_free, upd_done;
	logic                      ram_we, ram_re;
	logic [VALUE_W-1:0]        ram_rdata;
	logic signed [DELTA_W-1:0] diff;
	logic [DELTA_W-1:0]        abs_diff;
	logic                      scan_last;
	logic signed [PRED_W:0]    psum;
	logic signed [PRED_W-1:0]  psat;

	assign cfg_ready   = 1'b1;
	assign in_ready    = (state_q == ST_IDLE);
	assign in_fire     = in_valid && in_ready;
	assign ch_ok       = (int'(channel) < MAX_CHANNELS);
	assign ent_ok      = (int'(entry_index) < TABLE_DEPTH);
	assign out_free    = !out_valid_q || out_ready;
	assign out_valid   = out_valid_q;
	assign packed_word = word_q;
	assign last_word   = last_q;

	// effective table size and code width
	always_comb begin
		if (table_entries_q == '0) begin
			n_d = CNT_W'(1);
		end else if (int'(table_entries_q) > TABLE_DEPTH) begin
			n_d = CNT_W'(TABLE_DEPTH);
		end else begin
			n_d = CNT_W'(table_entries_q);
		end
		if (code_bits_q == 3'd0) begin
			bits = 3'd1;
		end else if (int'(code_bits_q) > CODE_BITS_MAX) begin
			bits = 3'(CODE_BITS_MAX);
		end else begin
			bits = code_bits_q;
		end
	end

	// quantizer table
	assign ram_we = in_fire && (op == OP_WRITE) && ent_ok;
	assign ram_re = (state_q == ST_SCAN) && (addr_q != n_q);

	dtqp_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (TABLE_DEPTH)
	) u_table_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (IDX_W'(entry_index)),
		.wdata (value),
		.re    (ram_re),
		.raddr (addr_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	// shared distance unit
	assign diff = DELTA_W'($signed(ram_rdata)) - delta_q;
	assign abs_diff = diff[DELTA_W-1] ? DELTA_W'(-diff) : DELTA_W'(diff);
	assign scan_last = cmp_v_s1 && (cmp_idx_s1 == n_q - CNT_W'(1));

	// predictor update with saturation
	always_comb begin
		psum = (PRED_W+1)'(pred_q[ch_q]) + (PRED_W+1)'(bestv_q);
		if (psum > PRED_MAX) begin
			psat = PRED_W'(PRED_MAX);
		end else if (psum < PRED_MIN) begin
			psat = PRED_W'(PRED_MIN);
		end else begin
			psat = PRED_W'(psum);
		end
	end

	// packer
	always_comb begin
		code    = CODE_BITS_MAX'(best_q) & ~({CODE_BITS_MAX{1'b1}} << bits);
		new_acc = acc_q | (WORD_BITS'(code) << pos_q);
		new_pos = pos_q + POS_W'(bits);
		emit    = ((int'(new_pos) + int'(bits)) > WORD_BITS) || fend_q;
	end

	// next state
	always_comb begin
		state_d  = state_q;
		upd_done = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && (op == OP_ENCODE) && ch_ok) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (!emit || out_free) begin
					upd_done = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_bits_q     <= CODE_BITS_RST;
			table_entries_q <= TABLE_ENTRIES_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_CODE_BITS) begin
				code_bits_q <= cfg_data[2:0];
			end else if (cfg_index == REG_TABLE_ENTRIES) begin
				table_entries_q <= cfg_data;
			end
		end
	end

	// predictors and packer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				pred_q[i] <= '0;
			end
			acc_q <= '0;
			pos_q <= '0;
		end else if (in_fire && (op == OP_START) && ch_ok) begin
			pred_q[CH_W'(channel)] <= PRED_W'(value);
		end else if (upd_done) begin
			pred_q[ch_q] <= psat;
			if (emit) begin
				acc_q <= '0;
				pos_q <= '0;
			end else begin
				acc_q <= new_acc;
				pos_q <= new_pos;
			end
		end
	end

	// scan sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q   <= '0;
			cmp_v_s1 <= 1'b0;
		end else if (in_fire) begin
			addr_q   <= '0;
			cmp_v_s1 <= 1'b0;
		end else if (state_q == ST_SCAN) begin
			cmp_v_s1 <= ram_re;
			if (ram_re) begin
				addr_q <= addr_q + CNT_W'(1);
			end
		end else begin
			cmp_v_s1 <= 1'b0;
		end
	end

	// item capture and best-entry tracking
	always_ff @(posedge clk) begin
		if (in_fire) begin
			ch_q    <= CH_W'(channel);
			delta_q <= DELTA_W'(value) - DELTA_W'(pred_q[CH_W'(channel)]);
			fend_q  <= frame_end;
			n_q     <= n_d;
		end
		if (state_q == ST_SCAN) begin
			cmp_idx_s1 <= addr_q;
		end
		if (cmp_v_s1 && ((cmp_idx_s1 == '0) || (abs_diff < bestd_q))) begin
			best_q  <= cmp_idx_s1[IDX_W-1:0];
			bestd_q <= abs_diff;
			bestv_q <= $signed(ram_rdata);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_done && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_done && emit) begin
			word_q <= new_acc;
			last_q <= fend_q;
		end
	end

	// checks
	a_pos_below_word: assert property (@(posedge clk) disable iff (!arst_n)
		int'(pos_q) < WORD_BITS)
		else $error("packer bit position reached word width");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_done && emit) |=> (pos_q == '0) && (acc_q == '0) && out_valid_q)
		else $error("emitted word did not clear packer");

	a_encode_scans: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (op == OP_ENCODE) && ch_ok) |=> (state_q == ST_SCAN) && (addr_q == '0))
		else $error("encode item did not start a scan");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_v_s1 |-> (cmp_idx_s1 < n_q) && (state_q == ST_SCAN))
		else $error("compare index outside searched entries");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> $stable(word_q) && $stable(last_q))
		else $error("waiting word was overwritten");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the dpcm table quantizer and packer.
// Loads the quantizer table, walks a short directed list (reset values,
// extremes, ties, saturation, out-of-range registers), then runs random
// frames under several register settings with random idle bursts on both
// sides. Every output word is checked against a built-in predictor or a known word.
// ----------------------------------------------------------------------------
module tb;
	import dtqp_pkg::*;

	localparam int WORD_W        = 16;
	localparam int TABLE_N       = 32;
	localparam int CHAN_N        = 4;
	localparam int SETTLE_CYCLES = 48;
	localparam int PHASE_ITEMS   = 50;
	localparam int PHASE_N       = 10;
	localparam int CYCLE_LIMIT   = 400000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		op_t         o;
		logic [1:0]  ch;
		logic [4:0]  ei;
		logic [15:0] val;
		logic        fend;
	} sample_item_t;

	typedef struct packed {
		logic [15:0] word;
		logic        last;
	} word_exp_t;

	typedef struct packed {
		logic                  is_reg;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_dat;
		sample_item_t          it;
		logic                  known;
		logic                  known_has;
		word_exp_t             known_exp;
	} dir_row_t;

	// block ports
	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  in_valid    = 1'b0;
	logic                  in_ready;
	op_t                   op          = OP_WRITE;
	logic [1:0]            channel     = '0;
	logic [4:0]            entry_index = '0;
	logic signed [15:0]    value       = '0;
	logic                  frame_end   = 1'b0;
	logic                  out_valid;
	logic                  out_ready   = 1'b0;
	logic [WORD_W-1:0]     packed_word;
	logic                  last_word;
	logic                  cfg_valid   = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index   = '0;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;

	// predictor state
	logic signed [15:0] qtab [TABLE_N];
	logic signed [17:0] chan_pred [CHAN_N];
	logic [31:0]        pack_acc;
	int                 pack_pos;
	logic [2:0]         code_bits_r;
	logic [5:0]         entries_r;

	word_exp_t pending_words [$];
	word_exp_t got_exp;
	dir_row_t  dir_rows [$];

	int errors     = 0;
	int cycles     = 0;
	int gap_pct    = 0;
	int stall_pct  = 0;
	int ready_hold = 0;
	int sent       = 0;

	int phase_code [PHASE_N] = '{4, 1, 5, 3, 7, 2, 0, 5, 6, 4};
	int phase_ents [PHASE_N] = '{16, 32, 32, 8, 63, 2, 0, 1, 33, 32};

	dpcm_table_quantizer_packer u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.channel     (channel),
		.entry_index (entry_index),
		.value       (value),
		.frame_end   (frame_end),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.packed_word (packed_word),
		.last_word   (last_word),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// clock
	initial begin
		forever #4 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		errors++;
	endtask

	// output side: check each accepted word, then pick the next ready level
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_words.size() == 0) begin
				report_mismatch($sformatf("word %h with nothing expected", packed_word));
			end else begin
				got_exp = pending_words.pop_front();
				if (packed_word !== got_exp.word)
					report_mismatch($sformatf("packed_word %h, expected %h",
						packed_word, got_exp.word));
				if (last_word !== got_exp.last)
					report_mismatch($sformatf("last_word %b, expected %b",
						last_word, got_exp.last));
			end
		end
		if (ready_hold > 0) begin
			ready_hold--;
			out_ready <= 1'b0;
		end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
			ready_hold = $urandom_range(0, 18);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// encoder predictor: table, per-channel predictor, index packer
	task automatic dpcm_step(input sample_item_t it, output bit emits, output word_exp_t w);
		int bits, n, j, best, bestd, d, v, delta, cur, p;
		emits = 1'b0;
		w     = '0;
		v     = $signed(it.val);
		case (it.o)
			OP_WRITE: qtab[it.ei] = it.val;
			OP_START: chan_pred[it.ch] = v[17:0];
			OP_ENCODE: begin
				bits = (code_bits_r < 1) ? 1 :
					(code_bits_r > CODE_BITS_MAX) ? CODE_BITS_MAX : code_bits_r;
				n = (entries_r == 0) ? 1 : (entries_r > TABLE_N) ? TABLE_N : entries_r;
				cur   = chan_pred[it.ch];
				delta = v - cur;
				best  = 0;
				bestd = 0;
				// nearest entry, lowest index wins a tie
				for (j = 0; j < n; j++) begin
					d = int'(qtab[j]) - delta;
					if (d < 0)
						d = -d;
					if (j == 0 || d < bestd) begin
						bestd = d;
						best  = j;
					end
				end
				p = cur + int'(qtab[best]);
				if (p > PRED_MAX)
					p = PRED_MAX;
				if (p < PRED_MIN)
					p = PRED_MIN;
				chan_pred[it.ch] = p[17:0];
				// pack lsb-first, emit when the next index would not fit or at frame end
				pack_acc = pack_acc | ((32'(best) & ((32'd1 << bits) - 32'd1)) << pack_pos);
				pack_pos += bits;
				if (pack_pos + bits > WORD_W || (it.fend && pack_pos > 0)) begin
					emits    = 1'b1;
					w.word   = pack_acc[15:0];
					w.last   = it.fend;
					pack_acc = '0;
					pack_pos = 0;
				end
			end
			default: ;
		endcase
	endtask

	// optional idle burst, then hold the item until it is taken
	task automatic send_item(input sample_item_t it, input logic known,
			input logic known_has, input word_exp_t known_exp);
		bit        emits;
		word_exp_t w;
		if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		op          <= it.o;
		channel     <= it.ch;
		entry_index <= it.ei;
		value       <= it.val;
		frame_end   <= it.fend;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		dpcm_step(it, emits, w);
		if (known) begin
			emits = known_has;
			w     = known_exp;
		end
		if (emits)
			pending_words.push_back(w);
		if (it.o != OP_NONE)
			sent++;
	endtask

	// wait for every word, then let an encode still in flight finish
	task automatic drain_and_settle();
		in_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] dat);
		drain_and_settle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= dat;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_CODE_BITS:     code_bits_r = dat[2:0];
			REG_TABLE_ENTRIES: entries_r   = dat;
			default: ;
		endcase
	endtask

	function automatic dir_row_t item_row(input op_t o, input int ch, input int ei,
			input int val, input logic fend);
		dir_row_t r;
		r         = '0;
		r.it.o    = o;
		r.it.ch   = ch[1:0];
		r.it.ei   = ei[4:0];
		r.it.val  = val[15:0];
		r.it.fend = fend;
		return r;
	endfunction

	function automatic dir_row_t known_row(input op_t o, input int ch, input int ei,
			input int val, input logic fend, input logic has, input int word, input logic last);
		dir_row_t r;
		r                = item_row(o, ch, ei, val, fend);
		r.known          = 1'b1;
		r.known_has      = has;
		r.known_exp.word = word[15:0];
		r.known_exp.last = last;
		return r;
	endfunction

	function automatic dir_row_t reg_row(input logic [CFG_IDX_W-1:0] idx, input int dat);
		dir_row_t r;
		r         = '0;
		r.is_reg  = 1'b1;
		r.reg_idx = idx;
		r.reg_dat = dat[CFG_DATA_W-1:0];
		return r;
	endfunction

	// full-range sample or one near the given level
	function automatic logic [15:0] pick_value(input int center);
		int v;
		if ($urandom_range(0, 9) < 4)
			return 16'($urandom);
		v = center + int'($urandom_range(0, 4095)) - 2048;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[15:0];
	endfunction

	// mostly whole frames on one channel, some stray items in between
	task automatic run_phase(input int n_items);
		sample_item_t it;
		int           ch, len, k, stop_at;
		stop_at = sent + n_items;
		while (sent < stop_at) begin
			if ($urandom_range(0, 99) < 15) begin
				it.o    = ($urandom_range(0, 4) < 2) ? OP_WRITE : op_t'($urandom_range(1, 3));
				it.ch   = 2'($urandom_range(0, CHAN_N - 1));
				it.ei   = 5'($urandom_range(0, TABLE_N - 1));
				it.val  = pick_value(0);
				it.fend = 1'($urandom_range(0, 1));
				send_item(it, 1'b0, 1'b0, '0);
			end else begin
				ch = $urandom_range(0, CHAN_N - 1);
				len = $urandom_range(1, 12);
				if ($urandom_range(0, 3) == 0) begin
					it.o    = OP_START;
					it.ch   = ch[1:0];
					it.ei   = 5'($urandom_range(0, TABLE_N - 1));
					it.val  = pick_value(int'(chan_pred[ch]));
					it.fend = 1'b0;
					send_item(it, 1'b0, 1'b0, '0);
				end
				for (k = 0; k < len; k++) begin
					it.o    = OP_ENCODE;
					it.ch   = ch[1:0];
					it.ei   = 5'($urandom_range(0, TABLE_N - 1));
					it.val  = pick_value(int'(chan_pred[ch]));
					it.fend = (k == len - 1);
					send_item(it, 1'b0, 1'b0, '0);
				end
			end
		end
	endtask

	// stimulus
	initial begin
		int       j, ph, tval;
		dir_row_t r;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		code_bits_r = CODE_BITS_RST;
		entries_r   = TABLE_ENTRIES_RST;
		pack_acc    = '0;
		pack_pos    = 0;
		for (j = 0; j < CHAN_N; j++)
			chan_pred[j] = '0;
		for (j = 0; j < TABLE_N; j++)
			qtab[j] = '0;

		gap_pct   = 25;
		stall_pct = 25;

		// table load: zero, both extremes, then an even ramp (entry 17 repeats zero)
		for (j = 0; j < TABLE_N; j++) begin
			tval = (j == 0) ? 0 : (j == 1) ? 32767 : (j == 2) ? -32768 : (j - 17) * 96;
			r = item_row(OP_WRITE, 0, j, tval, 1'b0);
			send_item(r.it, 1'b0, 1'b0, '0);
		end

		// reset registers: 4-bit codes, 16 entries searched
		dir_rows.push_back(known_row(OP_ENCODE, 0, 0, 0, 1'b1, 1'b1, 16'h0000, 1'b1));
		dir_rows.push_back(known_row(OP_ENCODE, 0, 0, 32767, 1'b1, 1'b1, 16'h0001, 1'b1));
		dir_rows.push_back(known_row(OP_ENCODE, 1, 0, -32768, 1'b1, 1'b1, 16'h0002, 1'b1));
		dir_rows.push_back(known_row(OP_NONE, 2, 31, -1, 1'b1, 1'b0, 0, 1'b0));
		dir_rows.push_back(known_row(OP_START, 2, 0, -32768, 1'b1, 1'b0, 0, 1'b0));
		dir_rows.push_back(known_row(OP_WRITE, 3, 31, 1344, 1'b1, 1'b0, 0, 1'b0));
		// four codes fill a word without frame end
		dir_rows.push_back(item_row(OP_ENCODE, 3, 0, 96, 1'b0));
		dir_rows.push_back(item_row(OP_ENCODE, 3, 0, -200, 1'b0));
		dir_rows.push_back(item_row(OP_ENCODE, 3, 0, 5000, 1'b0));
		dir_rows.push_back(item_row(OP_ENCODE, 3, 0, -5000, 1'b0));
		dir_rows.push_back(item_row(OP_ENCODE, 2, 0, 32767, 1'b1));
		// unused register index, code width and table size above range
		dir_rows.push_back(reg_row(REG_UNUSED, 6'h2A));
		dir_rows.push_back(reg_row(REG_CODE_BITS, 7));
		dir_rows.push_back(reg_row(REG_TABLE_ENTRIES, 63));
		// ties: zero at entries 0 and 17, then 48 halfway between 0 and 96
		dir_rows.push_back(item_row(OP_ENCODE, 0, 0, 32767, 1'b0));
		dir_rows.push_back(item_row(OP_START, 0, 0, 0, 1'b0));
		dir_rows.push_back(item_row(OP_ENCODE, 0, 0, 48, 1'b1));
		// zero registers act as one: single entry drives the predictor to saturation
		dir_rows.push_back(reg_row(REG_CODE_BITS, 0));
		dir_rows.push_back(reg_row(REG_TABLE_ENTRIES, 0));
		dir_rows.push_back(item_row(OP_WRITE, 0, 0, 32767, 1'b0));
		dir_rows.push_back(item_row(OP_START, 1, 0, 32767, 1'b0));
		for (j = 0; j < 4; j++)
			dir_rows.push_back(item_row(OP_ENCODE, 1, 0, 32767, j == 3));
		dir_rows.push_back(item_row(OP_WRITE, 0, 0, -32768, 1'b0));
		dir_rows.push_back(item_row(OP_START, 1, 0, -32768, 1'b0));
		for (j = 0; j < 4; j++)
			dir_rows.push_back(item_row(OP_ENCODE, 1, 0, -32768, j == 3));
		dir_rows.push_back(item_row(OP_WRITE, 0, 0, 0, 1'b0));

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_reg)
				write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_dat);
			else
				send_item(dir_rows[i].it, dir_rows[i].known, dir_rows[i].known_has,
					dir_rows[i].known_exp);
		end

		// random phases; upper data bits on the code width write must be ignored
		for (ph = 0; ph < PHASE_N; ph++) begin
			write_reg(REG_CODE_BITS,
				CFG_DATA_W'(phase_code[ph] | ($urandom_range(0, 7) << 3)));
			write_reg(REG_TABLE_ENTRIES, CFG_DATA_W'(phase_ents[ph]));
			if (ph == PHASE_N - 1 || ph % 3 == 0) begin
				gap_pct   = 0;
				stall_pct = 0;
			end else if (ph % 3 == 1) begin
				gap_pct   = 12;
				stall_pct = 35;
			end else begin
				gap_pct   = 35;
				stall_pct = 12;
			end
			run_phase(PHASE_ITEMS);
		end

		drain_and_settle();
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* sim.f */
design/dtqp_pkg.sv
design/dtqp_ram.sv
design/dpcm_table_quantizer_packer.sv
tb/sv/tb.sv
